### rtl/stfs_pkg.sv
// ----------------------------------------------------------------------------
// stfs_pkg
// Shared types and constants for the full-step stepper sequencer.
// ----------------------------------------------------------------------------
package stfs_pkg;

	localparam int STEP_W     = 16;
	localparam int INTERVAL_W = 24;
	localparam int COIL_W     = 4;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd5000;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_MOVE = 1'b1;

	// two-phase-on patterns, coil A in bit 0
	localparam logic [COIL_W-1:0] COIL_PH0 = 4'h9;
	localparam logic [COIL_W-1:0] COIL_PH1 = 4'hA;
	localparam logic [COIL_W-1:0] COIL_PH2 = 4'h6;
	localparam logic [COIL_W-1:0] COIL_PH3 = 4'h5;

	typedef struct packed {
		logic              cmd;
		logic              move_backward;
		logic [STEP_W-1:0] step_count;
	} item_t;

	typedef struct packed {
		logic [COIL_W-1:0] coil_drive;
		logic              busy_res;
		logic [STEP_W-1:0] steps_left;
		logic              stepped;
	} res_t;

	function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] ph);
		logic [COIL_W-1:0] pat;
		case (ph)
			2'd0: pat = COIL_PH0;
			2'd1: pat = COIL_PH1;
			2'd2: pat = COIL_PH2;
			2'd3: pat = COIL_PH3;
			default: pat = COIL_PH0;
		endcase
		return pat;
	endfunction

endpackage

### rtl/stfs_step_core.sv
// ----------------------------------------------------------------------------
// stfs_step_core
// Phase, step count and tick timer; works out the result of one item.
// ----------------------------------------------------------------------------
module stfs_step_core #(
	parameter int COUNT_WIDTH = 16,
	parameter int TIMER_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  stfs_pkg::item_t                     item,
	input  logic [stfs_pkg::INTERVAL_W-1:0]     interval,
	output stfs_pkg::res_t                      res_next
);
	import stfs_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > INTERVAL_W) ? TIMER_WIDTH : INTERVAL_W;

	logic [1:0]             phase_q;
	logic [COUNT_WIDTH-1:0] remaining_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic                   backward_q;

	logic [1:0]                    phase_d;
	logic [COUNT_WIDTH-1:0]        remaining_d;
	logic [TIMER_WIDTH-1:0]        elapsed_d;
	logic                          backward_d;
	logic                          step_d;
	logic [TIMER_WIDTH-1:0]        elapsed_inc;
	logic                          timer_max;
	logic                          reached;
	logic [CMP_W+TIMER_WIDTH-1:0]  elapsed_wide;
	logic [CMP_W+INTERVAL_W-1:0]   interval_wide;
	logic [COUNT_WIDTH+STEP_W-1:0] count_wide;
	logic [COUNT_WIDTH+STEP_W-1:0] left_wide;

	assign timer_max   = (elapsed_q == {TIMER_WIDTH{1'b1}});
	assign elapsed_inc = timer_max ? elapsed_q : elapsed_q + 1'b1;

	// zero extension to a common compare width
	assign elapsed_wide  = {{CMP_W{1'b0}}, elapsed_inc};
	assign interval_wide = {{CMP_W{1'b0}}, interval};
	assign reached = (elapsed_wide[CMP_W-1:0] >= interval_wide[CMP_W-1:0])
		|| (elapsed_inc == {TIMER_WIDTH{1'b1}});

	assign count_wide = {{COUNT_WIDTH{1'b0}}, item.step_count};

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		elapsed_d   = elapsed_q;
		backward_d  = backward_q;
		step_d      = 1'b0;
		if (item.cmd == CMD_MOVE) begin
			remaining_d = count_wide[COUNT_WIDTH-1:0];
			backward_d  = item.move_backward;
			elapsed_d   = '0;
		end else if (remaining_q != '0) begin
			elapsed_d = elapsed_inc;
			if (reached) begin
				phase_d     = backward_q ? phase_q - 2'd1 : phase_q + 2'd1;
				remaining_d = remaining_q - 1'b1;
				elapsed_d   = '0;
				step_d      = 1'b1;
			end
		end
	end

	assign left_wide = {{STEP_W{1'b0}}, remaining_d};

	always_comb begin
		res_next.coil_drive = coil_pattern(phase_d);
		res_next.busy_res   = (remaining_d != '0);
		res_next.steps_left = left_wide[STEP_W-1:0];
		res_next.stepped    = step_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			remaining_q <= '0;
			elapsed_q   <= '0;
			backward_q  <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			elapsed_q   <= elapsed_d;
			backward_q  <= backward_d;
		end
	end

endmodule

### rtl/stepper_full_step_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer
// Two-phase-on full-step sequencer for a four-coil stepper motor.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  item     | item_valid / item_stall  | cmd, move_backward, step_count
//  result   | res_valid / res_stall    | coil_drive, busy_res, steps_left,
//           |                          | stepped
//  config   | cfg_valid / cfg_ready    | cfg_data (step interval, 24 bits)
//
//  one item per clock unless res_stall holds; input register, result register
//  the timer compare and phase update sit between those two registers
//  reset clears state; interval resets to 5000 ticks; cfg_ready is always high
//  res_stall holds the result register, which backs up into item_stall while
//  the input register is occupied
// ----------------------------------------------------------------------------
module stepper_full_step_sequencer #(
	parameter int COUNT_WIDTH = 16,
	parameter int TIMER_WIDTH = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   cmd,
	input  logic                                   move_backward,
	input  logic [stfs_pkg::STEP_W-1:0]            step_count,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [stfs_pkg::COIL_W-1:0]            coil_drive,
	output logic                                   busy_res,
	output logic [stfs_pkg::STEP_W-1:0]            steps_left,
	output logic                                   stepped,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [stfs_pkg::INTERVAL_W-1:0]        cfg_data
);
	import stfs_pkg::*;

	logic                  valid_s1;
	item_t                 item_s1;
	logic [INTERVAL_W-1:0] interval_q;
	logic                  res_valid_q;
	res_t                  res_q;
	res_t                  res_next;
	logic                  res_free;
	logic                  fire;

	assign cfg_ready  = 1'b1;
	assign res_free   = !res_valid_q || !res_stall;
	assign fire       = valid_s1 && res_free;
	assign item_stall = valid_s1 && !res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.cmd           <= cmd;
			item_s1.move_backward <= move_backward;
			item_s1.step_count    <= step_count;
		end
	end

	stfs_step_core #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.interval (interval_q),
		.res_next (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign res_valid  = res_valid_q;
	assign coil_drive = res_q.coil_drive;
	assign busy_res   = res_q.busy_res;
	assign steps_left = res_q.steps_left;
	assign stepped    = res_q.stepped;

	// input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (res_valid_q && res_stall))
		else $error("item stall without a held result");

	// a step worked out in the core lands in the result register
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_next.stepped) |=> (res_valid_q && res_q.stepped))
		else $error("step lost on the way to the result register");

	// a taken result with nothing behind it empties the result register
	a_res_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_stall && !fire) |=> !res_valid_q)
		else $error("result repeated after transfer");

endmodule
